@@ hdl/pointer_report_coalescer_assert.svh @@
// Assertion macros used by the pointer report coalescer checker.
// Expects a clock named clk and a synchronous active-high reset named rst.
`ifndef POINTER_REPORT_COALESCER_ASSERT_SVH
`define POINTER_REPORT_COALESCER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define PRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that must hold at every edge, reset included.
`define PRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/prc_pkg.sv @@
// Package for the pointer report coalescer: codes, widths, queue sizing, the
// 16-bit saturation helper and the queue pointer helper. No dependencies.
`timescale 1ns / 1ps

package prc_pkg;

  // Button-edge snapshot queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int NUM_BUTTONS = 5;
  localparam int STALE_W = 16;
  localparam logic [STALE_W-1:0] STALE_RESET = 16'd100;

  localparam logic signed [15:0] DELTA_MIN = 16'sh8000;
  localparam logic signed [15:0] DELTA_MAX = 16'sh7FFF;

  // Stream widths.
  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = 5;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = 2;

  // Register map (index = paddr[2]).
  localparam logic REG_STALE_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ACT_MOTION = 2'd0,
    ACT_KEY    = 2'd1,
    ACT_OTHER  = 2'd2,
    ACT_RETRY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RK_REPORT    = 2'd0,
    RK_RETRY     = 2'd1,
    RK_UNHANDLED = 2'd2
  } kind_t;

  localparam logic [2:0] AXIS_X  = 3'd0;
  localparam logic [2:0] AXIS_Y  = 3'd1;
  localparam logic [2:0] AXIS_WV = 3'd2;
  localparam logic [2:0] AXIS_WH = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AGE,
    ST_PLAN,
    ST_REPLAY,
    ST_REPORT,
    ST_RETRY,
    ST_NOTHAND
  } state_t;

  // Saturate a 32-bit two's complement value to 16 bits.
  function automatic logic [15:0] sat16(input logic [31:0] v);
    logic fits;
    begin
      fits = (v[31:15] == 17'h00000) || (v[31:15] == 17'h1FFFF);
      if (fits) begin
        sat16 = v[15:0];
      end else if (v[31]) begin
        sat16 = DELTA_MIN;
      end else begin
        sat16 = DELTA_MAX;
      end
    end
  endfunction

  // Advance a queue pointer with wrap at the queue depth.
  function automatic logic [QIDX_W-1:0] qinc(input logic [QIDX_W-1:0] p);
    begin
      if (p == QIDX_W'(QUEUE_DEPTH - 1)) begin
        qinc = '0;
      end else begin
        qinc = p + 1'b1;
      end
    end
  endfunction

endpackage

@@ hdl/pointer_report_coalescer.sv @@
// Top level of the pointer report coalescer: input latch, sequencer, shared
// 32-bit adder, snapshot queue, output register and APB register. Uses prc_pkg.
`timescale 1ns / 1ps

// Pointer report coalescer. Input events arrive as one transfer each on the
// s_ stream and are handled one at a time: s_tready is high only while the
// sequencer is idle. A key or motion event first updates the motion sums or
// button mask through a single shared 32-bit adder; a retry expiry skips the
// update, and any other event for an endpoint that is not ready is handed
// back unhandled. Events that lead to a send then use the same adder to
// compute the motion age, and a plan step decides whether the report goes
// out. After that the results go out on the m_ stream, held while m_tready
// is low: first the queued button snapshots, oldest first, then the current
// report. The output register lets the block accept the next event while the
// last result of the previous one still waits. Configuration is a single APB
// register, stale_limit_ms at byte address 0, to be written only while the
// block is idle; there is no clearing pass after reset.
module pointer_report_coalescer (
  input  logic        clk,
  input  logic        rst,
  // Event input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata, low bit up: amount[31:0], endpoint_ready[32], link_busy[33],
  // now_ms[65:34], zero fill [71:66].
  input  logic [prc_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser, low bit up: action[1:0], sub_code[4:2].
  input  logic [prc_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic        s_tlast,        // sync_flag
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata, low bit up: button_mask[4:0], delta_x[20:5], delta_y[36:21],
  // wheel_v[52:37], wheel_h[68:53], zero fill [71:69].
  output logic [prc_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: result_kind[1:0].
  output logic [prc_pkg::M_TUSER_W-1:0] m_tuser,
  output logic        m_tlast,        // last_of_run
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register.
  logic [prc_pkg::STALE_W-1:0] stale_limit_ms;

  // Sequencer.
  prc_pkg::state_t state, state_next;

  // Latched input event.
  prc_pkg::action_t in_action;
  logic [2:0]       in_code;
  logic [31:0]      in_amount;
  logic             in_sync;
  logic             in_ready;
  logic             in_busy;
  logic [31:0]      in_now;

  // Coalescing state.
  logic [prc_pkg::NUM_BUTTONS-1:0] held_buttons, held_buttons_next;
  logic [31:0] sum_x, sum_x_next;
  logic [31:0] sum_y, sum_y_next;
  logic [31:0] sum_wheel_v, sum_wheel_v_next;
  logic [31:0] sum_wheel_h, sum_wheel_h_next;
  logic [31:0] accum_start, accum_start_next;
  logic [31:0] age, age_next;
  logic        changed, changed_next;
  logic        send_rep, send_rep_next;

  // Snapshot queue, kept as a ring: head is the oldest entry.
  logic [prc_pkg::NUM_BUTTONS-1:0] edge_q [prc_pkg::QUEUE_DEPTH];
  logic [prc_pkg::QIDX_W-1:0] q_head, q_head_next;
  logic [prc_pkg::QCNT_W-1:0] q_count, q_count_next;
  logic [prc_pkg::QCNT_W:0]   tail_sum;
  logic [prc_pkg::QIDX_W-1:0] q_tail;
  logic                       q_we;
  logic [prc_pkg::NUM_BUTTONS-1:0] q_wdata;

  // Shared adder.
  logic [31:0] alu_a, alu_b, alu_y;
  logic        alu_sub;

  // Output register load.
  logic        out_free;
  logic        out_load;
  prc_pkg::kind_t out_kind;
  logic [prc_pkg::NUM_BUTTONS-1:0] out_mask;
  logic [15:0] out_x, out_y, out_wv, out_wh;
  logic        out_last;

  prc_pkg::kind_t r_kind;
  logic [prc_pkg::NUM_BUTTONS-1:0] r_mask;
  logic [15:0] r_x, r_y, r_wv, r_wh;
  logic        r_last;

  // Helpers.
  logic                            s_fire;
  logic [prc_pkg::NUM_BUTTONS-1:0] btn_bit;
  logic                            sums_nz;
  logic                            is_stale;
  logic                            chg;

  assign s_fire   = s_tvalid && s_tready;
  assign s_tready = (state == prc_pkg::ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign alu_y    = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};
  assign btn_bit  = prc_pkg::NUM_BUTTONS'(1) << in_code;
  assign sums_nz  = |(sum_x | sum_y | sum_wheel_v | sum_wheel_h);
  assign is_stale = (accum_start != 32'd0) &&
                    ((age[31:16] != 16'd0) || (age[15:0] > stale_limit_ms));

  // The write slot is the entry after the newest; when the ring is full it
  // lands on the oldest entry, which is then dropped.
  assign tail_sum = (prc_pkg::QCNT_W+1)'(q_head) + (prc_pkg::QCNT_W+1)'(q_count);
  assign q_tail   = (tail_sum >= (prc_pkg::QCNT_W+1)'(prc_pkg::QUEUE_DEPTH)) ?
                    prc_pkg::QIDX_W'(tail_sum - (prc_pkg::QCNT_W+1)'(prc_pkg::QUEUE_DEPTH)) :
                    prc_pkg::QIDX_W'(tail_sum);

  // APB: always ready, one register.
  assign pready = 1'b1;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == prc_pkg::REG_STALE_LIMIT) begin
      prdata = {16'd0, stale_limit_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit_ms <= prc_pkg::STALE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == prc_pkg::REG_STALE_LIMIT)) begin
      stale_limit_ms <= pwdata[prc_pkg::STALE_W-1:0];
    end
  end

  // Sequencer: next state, shared adder operands and result loads.
  always_comb begin
    state_next        = state;
    held_buttons_next = held_buttons;
    sum_x_next        = sum_x;
    sum_y_next        = sum_y;
    sum_wheel_v_next  = sum_wheel_v;
    sum_wheel_h_next  = sum_wheel_h;
    accum_start_next  = accum_start;
    age_next          = age;
    changed_next      = changed;
    send_rep_next     = send_rep;
    q_head_next       = q_head;
    q_count_next      = q_count;
    q_we              = 1'b0;
    q_wdata           = held_buttons;
    alu_a             = 32'd0;
    alu_b             = in_amount;
    alu_sub           = 1'b0;
    chg               = 1'b0;
    out_load          = 1'b0;
    out_kind          = prc_pkg::RK_REPORT;
    out_mask          = '0;
    out_x             = 16'd0;
    out_y             = 16'd0;
    out_wv            = 16'd0;
    out_wh            = 16'd0;
    out_last          = 1'b0;

    case (state)
      prc_pkg::ST_IDLE: begin
        if (s_fire) begin
          state_next = prc_pkg::ST_EXEC;
        end
      end

      prc_pkg::ST_EXEC: begin
        // The adder takes the selected sum plus the motion delta.
        case (in_code)
          prc_pkg::AXIS_X:  alu_a = sum_x;
          prc_pkg::AXIS_Y:  alu_a = sum_y;
          prc_pkg::AXIS_WV: alu_a = sum_wheel_v;
          prc_pkg::AXIS_WH: alu_a = sum_wheel_h;
          default:          alu_a = 32'd0;
        endcase
        if (in_action == prc_pkg::ACT_RETRY) begin
          state_next = in_busy ? prc_pkg::ST_RETRY : prc_pkg::ST_AGE;
        end else if (!in_ready) begin
          state_next = prc_pkg::ST_NOTHAND;
        end else begin
          if (in_action == prc_pkg::ACT_MOTION) begin
            // A zero time stamp would read as empty, so it is stored as 1.
            if (accum_start == 32'd0) begin
              accum_start_next = (in_now == 32'd0) ? 32'd1 : in_now;
            end
            case (in_code)
              prc_pkg::AXIS_X:  sum_x_next       = alu_y;
              prc_pkg::AXIS_Y:  sum_y_next       = alu_y;
              prc_pkg::AXIS_WV: sum_wheel_v_next = alu_y;
              prc_pkg::AXIS_WH: sum_wheel_h_next = alu_y;
              default: ;
            endcase
          end else if ((in_action == prc_pkg::ACT_KEY) &&
                       (in_code < 3'(prc_pkg::NUM_BUTTONS))) begin
            held_buttons_next = (in_amount != 32'd0) ? (held_buttons | btn_bit) :
                                                      (held_buttons & ~btn_bit);
            chg = (held_buttons_next != held_buttons);
          end
          changed_next = chg;
          if (in_sync || chg) begin
            if (in_busy) begin
              if (chg) begin
                q_we    = 1'b1;
                q_wdata = held_buttons_next;
                if (q_count == prc_pkg::QCNT_W'(prc_pkg::QUEUE_DEPTH)) begin
                  q_head_next = prc_pkg::qinc(q_head);
                end else begin
                  q_count_next = q_count + 1'b1;
                end
                state_next = prc_pkg::ST_RETRY;
              end else begin
                state_next = prc_pkg::ST_IDLE;
              end
            end else begin
              state_next = prc_pkg::ST_AGE;
            end
          end else begin
            state_next = prc_pkg::ST_IDLE;
          end
        end
      end

      prc_pkg::ST_AGE: begin
        alu_a      = in_now;
        alu_b      = accum_start;
        alu_sub    = 1'b1;
        age_next   = alu_y;
        state_next = prc_pkg::ST_PLAN;
      end

      prc_pkg::ST_PLAN: begin
        if (in_action == prc_pkg::ACT_RETRY) begin
          send_rep_next = (accum_start != 32'd0) && !is_stale && sums_nz;
        end else begin
          send_rep_next = changed || !is_stale;
        end
        if (q_count != '0) begin
          state_next = prc_pkg::ST_REPLAY;
        end else if (send_rep_next) begin
          state_next = prc_pkg::ST_REPORT;
        end else begin
          sum_x_next       = 32'd0;
          sum_y_next       = 32'd0;
          sum_wheel_v_next = 32'd0;
          sum_wheel_h_next = 32'd0;
          accum_start_next = 32'd0;
          state_next       = prc_pkg::ST_IDLE;
        end
      end

      prc_pkg::ST_REPLAY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_mask     = edge_q[q_head];
          out_last     = (q_count == prc_pkg::QCNT_W'(1)) && !send_rep;
          q_head_next  = prc_pkg::qinc(q_head);
          q_count_next = q_count - 1'b1;
          if (q_count == prc_pkg::QCNT_W'(1)) begin
            if (send_rep) begin
              state_next = prc_pkg::ST_REPORT;
            end else begin
              sum_x_next       = 32'd0;
              sum_y_next       = 32'd0;
              sum_wheel_v_next = 32'd0;
              sum_wheel_h_next = 32'd0;
              accum_start_next = 32'd0;
              state_next       = prc_pkg::ST_IDLE;
            end
          end
        end
      end

      prc_pkg::ST_REPORT: begin
        if (out_free) begin
          out_load         = 1'b1;
          out_mask         = held_buttons;
          out_x            = prc_pkg::sat16(sum_x);
          out_y            = prc_pkg::sat16(sum_y);
          out_wv           = prc_pkg::sat16(sum_wheel_v);
          out_wh           = prc_pkg::sat16(sum_wheel_h);
          out_last         = 1'b1;
          sum_x_next       = 32'd0;
          sum_y_next       = 32'd0;
          sum_wheel_v_next = 32'd0;
          sum_wheel_h_next = 32'd0;
          accum_start_next = 32'd0;
          state_next       = prc_pkg::ST_IDLE;
        end
      end

      prc_pkg::ST_RETRY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = prc_pkg::RK_RETRY;
          out_last   = 1'b1;
          state_next = prc_pkg::ST_IDLE;
        end
      end

      prc_pkg::ST_NOTHAND: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = prc_pkg::RK_UNHANDLED;
          out_last   = 1'b1;
          state_next = prc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = prc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and coalescing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      sum_x        <= 32'd0;
      sum_y        <= 32'd0;
      sum_wheel_v  <= 32'd0;
      sum_wheel_h  <= 32'd0;
      accum_start  <= 32'd0;
      q_head       <= '0;
      q_count      <= '0;
      changed      <= 1'b0;
      send_rep     <= 1'b0;
    end else begin
      held_buttons <= held_buttons_next;
      sum_x        <= sum_x_next;
      sum_y        <= sum_y_next;
      sum_wheel_v  <= sum_wheel_v_next;
      sum_wheel_h  <= sum_wheel_h_next;
      accum_start  <= accum_start_next;
      q_head       <= q_head_next;
      q_count      <= q_count_next;
      changed      <= changed_next;
      send_rep     <= send_rep_next;
    end
  end

  // Payload registers: input latch, age and queue entries.
  always_ff @(posedge clk) begin
    age <= age_next;
    if (s_fire) begin
      in_action <= prc_pkg::action_t'(s_tuser[1:0]);
      in_code   <= s_tuser[4:2];
      in_amount <= s_tdata[31:0];
      in_ready  <= s_tdata[32];
      in_busy   <= s_tdata[33];
      in_now    <= s_tdata[65:34];
      in_sync   <= s_tlast;
    end
    if (q_we) begin
      edge_q[q_tail] <= q_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      r_kind <= out_kind;
      r_mask <= out_mask;
      r_x    <= out_x;
      r_y    <= out_y;
      r_wv   <= out_wv;
      r_wh   <= out_wh;
      r_last <= out_last;
    end
  end

  assign m_tdata = {3'd0, r_wh, r_wv, r_y, r_x, r_mask};
  assign m_tuser = r_kind;
  assign m_tlast = r_last;

endmodule

@@ hdl/prc_checker.sv @@
// Port-level checker for the pointer report coalescer, bound to the top level.
// Uses prc_pkg and the macros in pointer_report_coalescer_assert.svh.
`timescale 1ns / 1ps
`include "pointer_report_coalescer_assert.svh"

module prc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [prc_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [prc_pkg::M_TUSER_W-1:0]  m_tuser,
  input logic                           m_tlast
);

  // One event at a time: after a transfer in, the input side closes.
  `PRC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input accepted while busy")

  // Retry and not-handled results stand alone, so each one ends its run.
  `PRC_ASSERT(a_single_results_last, m_tvalid && (m_tuser != prc_pkg::RK_REPORT) |-> m_tlast, "single result without last")

  // Retry and not-handled results carry no buttons and no motion.
  `PRC_ASSERT(a_single_results_empty, !m_tvalid || (m_tuser == prc_pkg::RK_REPORT) || (m_tdata == '0), "non-report result with data")

  // A stalled result holds its contents.
  `PRC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

endmodule

bind pointer_report_coalescer prc_checker u_prc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the pointer report coalescer: directed and random
// event traffic with a cycle-accurate-free report predictor and a result checker.
// Depends on prc_pkg and pointer_report_coalescer.
`timescale 1ns / 1ps

module tb_top;

  // A run of this many cycles with no transfer on any port means the block hung.
  localparam int HANG_LIMIT = 1000;
  // Cycles to let the block settle after its last result before a register
  // write or the end of the run.
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_GAP = 16;
  localparam logic [2:0] KEY_NOT_BUTTON = 3'd5;

  // One input event as it travels on the s_ stream.
  typedef struct {
    prc_pkg::action_t action;
    logic [2:0]  sub_code;
    logic [31:0] amount;
    logic        sync;
    logic        ready;
    logic        busy;
    logic [31:0] now_ms;
  } pointer_event_t;

  // One result as it travels on the m_ stream.
  typedef struct {
    prc_pkg::kind_t kind;
    logic [4:0]  buttons;
    logic [15:0] dx;
    logic [15:0] dy;
    logic [15:0] wv;
    logic [15:0] wh;
    logic        last;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [prc_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [prc_pkg::S_TUSER_W-1:0] s_tuser = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [prc_pkg::M_TDATA_W-1:0] m_tdata;
  logic [prc_pkg::M_TUSER_W-1:0] m_tuser;
  logic                          m_tlast;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [2:0]                    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predictor state, kept in step with the block at every accepted transfer.
  logic [15:0] stale_limit = prc_pkg::STALE_RESET;
  logic [4:0]  held_buttons = '0;
  logic [31:0] sum_x = '0;
  logic [31:0] sum_y = '0;
  logic [31:0] sum_wv = '0;
  logic [31:0] sum_wh = '0;
  logic [31:0] motion_stamp = '0;   // zero means nothing accumulated
  logic [4:0]  snapshots [prc_pkg::QUEUE_DEPTH];
  int          snapshot_count = 0;

  report_t     pending_reports[$];  // results still owed by the block, oldest first
  report_t     run_reports[$];      // results of the event being predicted

  logic [31:0] clock_ms = '0;       // uptime stamped on generated events
  logic        steady = 1'b0;       // when set, neither side inserts idle cycles
  int          sent_count = 0;
  int          fail_count = 0;
  int          hang_cycles = 0;

  pointer_report_coalescer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Report predictor
  // ---------------------------------------------------------------------------

  // Reports carry motion clamped to the 16-bit signed range.
  function automatic logic [15:0] clamp16(logic [31:0] v);
    if ($signed(v) > prc_pkg::DELTA_MAX) return prc_pkg::DELTA_MAX;
    if ($signed(v) < prc_pkg::DELTA_MIN) return prc_pkg::DELTA_MIN;
    return v[15:0];
  endfunction

  function automatic void add_report(prc_pkg::kind_t kind, logic [4:0] buttons,
                                     logic [31:0] x, logic [31:0] y,
                                     logic [31:0] wv, logic [31:0] wh);
    report_t r;
    r.kind    = kind;
    r.buttons = buttons;
    r.dx      = clamp16(x);
    r.dy      = clamp16(y);
    r.wv      = clamp16(wv);
    r.wh      = clamp16(wh);
    r.last    = 1'b0;
    run_reports.push_back(r);
  endfunction

  function automatic void clear_motion();
    sum_x = '0;
    sum_y = '0;
    sum_wv = '0;
    sum_wh = '0;
    motion_stamp = '0;
  endfunction

  // Saved button edges go out oldest first as buttons-only reports.
  function automatic void replay_snapshots();
    for (int i = 0; i < snapshot_count; i++) begin
      add_report(prc_pkg::RK_REPORT, snapshots[i], '0, '0, '0, '0);
    end
    snapshot_count = 0;
  endfunction

  // A full queue loses its oldest snapshot to make room.
  function automatic void save_snapshot();
    if (snapshot_count >= prc_pkg::QUEUE_DEPTH) begin
      for (int i = 0; i + 1 < prc_pkg::QUEUE_DEPTH; i++) begin
        snapshots[i] = snapshots[i + 1];
      end
      snapshot_count = prc_pkg::QUEUE_DEPTH - 1;
    end
    snapshots[snapshot_count] = held_buttons;
    snapshot_count++;
  endfunction

  // Works out every result one accepted event causes and queues them.
  function automatic void compute_reports(pointer_event_t ev);
    logic [4:0]  prev;
    logic        changed;
    logic        stale;
    logic [31:0] age;
    changed = 1'b0;
    run_reports.delete();
    if (ev.action == prc_pkg::ACT_RETRY) begin
      // A retry expiry ignores readiness, frame end, sub code and amount.
      if (ev.busy) begin
        add_report(prc_pkg::RK_RETRY, '0, '0, '0, '0, '0);
      end else begin
        replay_snapshots();
        if (motion_stamp != 0) begin
          age = ev.now_ms - motion_stamp;
          if (age <= {16'd0, stale_limit} && (sum_x | sum_y | sum_wv | sum_wh) != 0) begin
            add_report(prc_pkg::RK_REPORT, held_buttons, sum_x, sum_y, sum_wv, sum_wh);
          end
          clear_motion();
        end
      end
    end else if (!ev.ready) begin
      add_report(prc_pkg::RK_UNHANDLED, '0, '0, '0, '0, '0);
    end else begin
      if (ev.action == prc_pkg::ACT_MOTION) begin
        // A stamp of zero would read as empty, so time zero is stored as one.
        if (motion_stamp == 0) motion_stamp = (ev.now_ms == 0) ? 32'd1 : ev.now_ms;
        case (ev.sub_code)
          prc_pkg::AXIS_X:  sum_x  = sum_x + ev.amount;
          prc_pkg::AXIS_Y:  sum_y  = sum_y + ev.amount;
          prc_pkg::AXIS_WV: sum_wv = sum_wv + ev.amount;
          prc_pkg::AXIS_WH: sum_wh = sum_wh + ev.amount;
          default: ;
        endcase
      end else if (ev.action == prc_pkg::ACT_KEY && ev.sub_code < KEY_NOT_BUTTON) begin
        prev = held_buttons;
        held_buttons[ev.sub_code] = (ev.amount != 0);
        changed = (held_buttons != prev);
      end
      if (ev.sync || changed) begin
        if (ev.busy) begin
          if (changed) begin
            save_snapshot();
            add_report(prc_pkg::RK_RETRY, '0, '0, '0, '0, '0);
          end
        end else begin
          replay_snapshots();
          // Old motion is thrown away on a frame end, but never on a button edge.
          stale = 1'b0;
          if (!changed && motion_stamp != 0) begin
            age = ev.now_ms - motion_stamp;
            stale = (age > {16'd0, stale_limit});
          end
          if (!stale) begin
            add_report(prc_pkg::RK_REPORT, held_buttons, sum_x, sum_y, sum_wv, sum_wh);
          end
          clear_motion();
        end
      end
    end
    if (run_reports.size() > 0) run_reports[run_reports.size() - 1].last = 1'b1;
    foreach (run_reports[i]) pending_reports.push_back(run_reports[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Every task below is entered and left just after a rising
  // edge, so each drives its signals once per time step.
  // ---------------------------------------------------------------------------

  function automatic pointer_event_t mk_event(prc_pkg::action_t action, logic [2:0] sub_code,
                                              logic [31:0] amount, logic sync,
                                              logic ready, logic busy);
    pointer_event_t ev;
    ev.action   = action;
    ev.sub_code = sub_code;
    ev.amount   = amount;
    ev.sync     = sync;
    ev.ready    = ready;
    ev.busy     = busy;
    ev.now_ms   = clock_ms;
    return ev;
  endfunction

  // Mostly short steps so that motion ages straddle the stale limit, with the
  // odd jump anywhere in the 32-bit range to exercise the wrap.
  function automatic void advance_clock();
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      8:       clock_ms = clock_ms + $urandom_range(61, 400);
      9:       clock_ms = $urandom;
      default: clock_ms = clock_ms + $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [31:0] random_amount();
    case ($urandom_range(0, 5))
      0:       return 32'($signed($urandom_range(0, 200)) - 100);
      1:       return 32'($signed($urandom_range(0, 80000)) - 40000);
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly real axes; now and then one of the codes the block ignores.
  function automatic logic [2:0] random_axis();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(4, 7));
    return 3'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] press_amount();
    logic [31:0] amt;
    amt = $urandom;
    if (amt == 0) amt = 32'd1;
    return amt;
  endfunction

  // Offers one event on the s_ stream, after a random number of idle cycles,
  // and predicts its results at the edge where the transfer happens.
  task automatic send_event(pointer_event_t ev);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, ev.now_ms, ev.busy, ev.ready, ev.amount};
    s_tuser  <= {ev.sub_code, ev.action};
    s_tlast  <= ev.sync;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    compute_reports(ev);
    sent_count++;
  endtask

  // Lets the block drain completely. Events that cause no result may still be
  // in flight when the last expected result arrives, hence the extra cycles.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  task automatic write_stale_limit(logic [15:0] value);
    logic [15:0] filler;
    filler = 16'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {prc_pkg::REG_STALE_LIMIT, 2'b00};
    pwdata  <= {filler, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stale_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Motion sums on every axis, wrap-free saturation in both directions, an
  // ignored axis, the first motion stamped at time zero, and two frame ends.
  task automatic test_saturation();
    clock_ms = '0;
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_X, 32'h7FFF_FFFF,
                        1'b0, 1'b1, 1'b0));
    clock_ms = 32'd20;
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_Y, 32'h8000_0000,
                        1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_WV, -32'sd5, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_WH, 32'd32767, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
    clock_ms = 32'd50;
    send_event(mk_event(prc_pkg::ACT_OTHER, 3'd6, 32'h0, 1'b1, 1'b1, 1'b0));
    // Values one past the 16-bit range on each side, and the exact minimum.
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_X, -32'sd32768, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_Y, 32'd32768, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_WH, -32'sd32769, 1'b1, 1'b1, 1'b0));
  endtask

  // Button edges with the link free and busy, a repeated press that changes
  // nothing, a key that is not a button, snapshot queue overrun, and retry
  // expiries with the link busy and then free.
  task automatic test_buttons_and_snapshots();
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd0, 32'd1, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd4, 32'h8000_0000, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd4, 32'd9, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd1, 32'd1, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd1, 32'd0, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd3, 32'd2, 1'b0, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd7, 32'd1, 1'b1, 1'b1, 1'b1));
    send_event(mk_event(prc_pkg::ACT_RETRY, 3'd0, 32'd0, 1'b0, 1'b0, 1'b1));
    send_event(mk_event(prc_pkg::ACT_RETRY, 3'd5, 32'd3, 1'b1, 1'b0, 1'b0));
  endtask

  // An event while the endpoint is not ready, an expiry with nothing to do,
  // motion that goes stale on a frame end, motion exactly at the age limit on
  // an expiry, and a button edge that sends old motion anyway.
  task automatic test_unhandled_and_stale();
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_X, 32'd5, 1'b1, 1'b0, 1'b0));
    send_event(mk_event(prc_pkg::ACT_RETRY, 3'd0, 32'd0, 1'b0, 1'b0, 1'b0));
    clock_ms = 32'hFFFF_FFC0;
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_X, 32'd10, 1'b0, 1'b1, 1'b0));
    clock_ms = clock_ms + 101;
    send_event(mk_event(prc_pkg::ACT_OTHER, 3'd0, 32'd0, 1'b1, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_Y, 32'd3, 1'b0, 1'b1, 1'b0));
    clock_ms = clock_ms + 100;
    send_event(mk_event(prc_pkg::ACT_RETRY, 3'd0, 32'd0, 1'b0, 1'b1, 1'b0));
    send_event(mk_event(prc_pkg::ACT_MOTION, prc_pkg::AXIS_WV, 32'd7, 1'b0, 1'b1, 1'b0));
    clock_ms = clock_ms + 500;
    send_event(mk_event(prc_pkg::ACT_KEY, 3'd2, 32'd0, 1'b0, 1'b1, 1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // One short, mostly well-formed sequence with random content.
  task automatic random_burst();
    int         shape;
    int         n;
    logic       busy;
    logic [2:0] btn;
    busy   = ($urandom_range(0, 4) == 0);
    steady = ($urandom_range(0, 4) == 0);
    shape  = $urandom_range(0, 9);
    case (shape)
      0, 1, 2, 3: begin
        // A motion frame; the frame end rides on the last motion or on a
        // separate event.
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          advance_clock();
          send_event(mk_event(prc_pkg::ACT_MOTION, random_axis(), random_amount(),
                              (i == n - 1) && shape != 3, 1'b1, busy));
        end
        if (shape == 3) begin
          advance_clock();
          send_event(mk_event($urandom_range(0, 1) ? prc_pkg::ACT_OTHER : prc_pkg::ACT_KEY,
                              3'($urandom_range(5, 7)), $urandom, 1'b1, 1'b1, busy));
        end
      end
      4, 5: begin
        // A click, possibly with motion between press and release.
        btn = 3'($urandom_range(0, 4));
        advance_clock();
        send_event(mk_event(prc_pkg::ACT_KEY, btn, press_amount(),
                            1'($urandom_range(0, 1)), 1'b1, busy));
        if ($urandom_range(0, 1)) begin
          advance_clock();
          send_event(mk_event(prc_pkg::ACT_MOTION, random_axis(), random_amount(),
                              1'b0, 1'b1, busy));
        end
        advance_clock();
        send_event(mk_event(prc_pkg::ACT_KEY, btn, '0, 1'($urandom_range(0, 1)), 1'b1, busy));
      end
      6: begin
        // A quiet link collecting button edges, then the retry that flushes them.
        n = $urandom_range(2, 6);
        for (int i = 0; i < n; i++) begin
          advance_clock();
          send_event(mk_event(prc_pkg::ACT_KEY, 3'($urandom_range(0, 4)),
                              $urandom_range(0, 1) ? press_amount() : '0,
                              1'($urandom_range(0, 1)), 1'b1, 1'b1));
          if ($urandom_range(0, 3) == 0) begin
            send_event(mk_event(prc_pkg::ACT_RETRY, 3'($urandom), $urandom, 1'($urandom),
                                1'($urandom), 1'b1));
          end
        end
        advance_clock();
        if ($urandom_range(0, 2) == 0) begin
          send_event(mk_event(prc_pkg::ACT_OTHER, 3'($urandom), $urandom, 1'b1, 1'b1, 1'b0));
        end else begin
          send_event(mk_event(prc_pkg::ACT_RETRY, 3'($urandom), $urandom, 1'($urandom),
                              1'($urandom), 1'b0));
        end
      end
      7: begin
        // Motion left pending and picked up by a retry expiry.
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          advance_clock();
          send_event(mk_event(prc_pkg::ACT_MOTION, random_axis(), random_amount(),
                              1'b0, 1'b1, busy));
        end
        advance_clock();
        send_event(mk_event(prc_pkg::ACT_RETRY, 3'($urandom), $urandom, 1'($urandom),
                            1'($urandom), $urandom_range(0, 3) == 0));
      end
      8: begin
        // Noise: every field drawn at random.
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          advance_clock();
          send_event(mk_event(prc_pkg::action_t'($urandom_range(0, 3)), 3'($urandom),
                              $urandom, 1'($urandom), 1'($urandom), 1'($urandom)));
        end
      end
      default: begin
        // Endpoint not ready: the event is handed back unhandled.
        advance_clock();
        send_event(mk_event(prc_pkg::action_t'($urandom_range(0, 2)), 3'($urandom),
                            random_amount(), 1'($urandom), 1'b0, 1'($urandom)));
      end
    endcase
  endtask

  // One phase of random traffic under a fresh stale limit, set while idle.
  task automatic test_random_traffic(int items, logic [15:0] limit);
    int target;
    wait_idle();
    write_stale_limit(limit);
    target = sent_count + items;
    while (sent_count < target) random_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, checking and hang detection
  // ---------------------------------------------------------------------------

  // Holds m_tready low for a random number of cycles before each result.
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    report_t want;
    report_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind    = prc_pkg::kind_t'(m_tuser);
      got.buttons = m_tdata[4:0];
      got.dx      = m_tdata[20:5];
      got.dy      = m_tdata[36:21];
      got.wv      = m_tdata[52:37];
      got.wh      = m_tdata[68:53];
      got.last    = m_tlast;
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result with none expected: kind %0d buttons %h x %h y %h v %h h %h last %b",
                   $realtime, got.kind, got.buttons, got.dx, got.dy, got.wv, got.wh, got.last);
        end
      end else begin
        want = pending_reports.pop_front();
        if (got.kind !== want.kind || got.buttons !== want.buttons || got.dx !== want.dx ||
            got.dy !== want.dy || got.wv !== want.wv || got.wh !== want.wh ||
            got.last !== want.last) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: expected kind %0d buttons %h x %h y %h v %h h %h last %b",
                     $realtime, want.kind, want.buttons, want.dx, want.dy, want.wv, want.wh,
                     want.last);
            $display("%0t: got      kind %0d buttons %h x %h y %h v %h h %h last %b",
                     $realtime, got.kind, got.buttons, got.dx, got.dy, got.wv, got.wh,
                     got.last);
          end
        end
      end
    end
  end

  // Any transfer on either stream or the register port counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_saturation();
    test_buttons_and_snapshots();
    test_unhandled_and_stale();

    // The limit runs through both extremes, a random value and back to the
    // reset value.
    test_random_traffic(60, 16'hFFFF);
    test_random_traffic(55, 16'd0);
    test_random_traffic(55, 16'($urandom_range(1, 600)));
    test_random_traffic(55, prc_pkg::STALE_RESET);

    wait_idle();
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/prc_pkg.sv
hdl/pointer_report_coalescer.sv
hdl/prc_checker.sv
sim/tb_top.sv
